// ----- design/pkht_pkg.sv -----
package pkht_pkg;

  localparam int KEY_W  = 20;
  localparam int PAY_W  = 32;
  localparam int STAT_W = 2;

  localparam int BUCKETS_DEF = 256;
  localparam int WAYS_DEF    = 4;

  typedef enum logic {
    CMD_ADD = 1'b0,
    CMD_GET = 1'b1
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_ZERO = 2'd2
  } status_t;

endpackage

// ----- design/pkht_if.sv -----
interface pkht_in_if;
  logic                       valid;
  logic                       ready;
  logic                       command;
  logic [pkht_pkg::KEY_W-1:0] pid_key;
  logic [pkht_pkg::PAY_W-1:0] payload_in;

  modport source (output valid, output command, output pid_key, output payload_in,
                  input ready);
  modport sink   (input valid, input command, input pid_key, input payload_in,
                  output ready);
endinterface

interface pkht_out_if;
  logic                        valid;
  logic                        ready;
  logic                        found;
  logic [pkht_pkg::PAY_W-1:0]  payload_out;
  logic [pkht_pkg::STAT_W-1:0] status;

  modport source (output valid, output found, output payload_out, output status,
                  input ready);
  modport sink   (input valid, input found, input payload_out, input status,
                  output ready);
endinterface

// ----- design/pid_keyed_hash_table.sv -----
// PID-keyed lookup table: BUCKETS buckets of WAYS ways each, bucket = pid_key mod
// BUCKETS. An add fills the lowest free way of the bucket (status 1 if the bucket
// is full, status 2 if the payload is zero); a get returns the payload of the
// lowest occupied way holding the key, or found = 0 with payload zero. Each
// command gives exactly one result. The block takes one command every cycle while
// the output is not stalled; a command passes through the input register, the
// bucket reduction, the bucket row read and the compare and write back into the
// result register, where the result waits while the output is stalled. A command
// reads the row that the command just ahead of it writes, through a forwarding
// register, so back-to-back commands on one bucket see each other. After reset a
// clearing pass empties the occupancy memory, one bucket row per cycle; no input is taken until it ends.
module pid_keyed_hash_table #(
  parameter int BUCKETS = pkht_pkg::BUCKETS_DEF,
  parameter int WAYS    = pkht_pkg::WAYS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  pkht_in_if.sink     in_if,
  pkht_out_if.source  out_if
);

  localparam int KEY_W = pkht_pkg::KEY_W;
  localparam int PAY_W = pkht_pkg::PAY_W;
  localparam int BKT_W = $clog2(BUCKETS);
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;

  // floor(key / BUCKETS) = (key * RECIP_M) >> RECIP_S, exact for every 20-bit key
  localparam int              RECIP_S = KEY_W + BKT_W;
  localparam longint unsigned RECIP_M = ((64'd1 << RECIP_S) + BUCKETS - 1) / BUCKETS;
  localparam logic [KEY_W:0]  MUL_M   = RECIP_M[KEY_W:0];
  localparam logic [BKT_W:0]  BKT_NUM = BUCKETS[BKT_W:0];

  // bucket row storage
  logic [WAYS-1:0]                 occ_mem [BUCKETS];
  logic [WAYS-1:0][KEY_W-1:0]      key_mem [BUCKETS];
  logic [WAYS-1:0][PAY_W-1:0]      pay_mem [BUCKETS];

  logic             clr_active_r;
  logic [BKT_W-1:0] clr_idx_r;

  // stage P: input register
  logic             p_valid_r;
  logic             p_cmd_r;
  logic [KEY_W-1:0] p_key_r;
  logic [PAY_W-1:0] p_pay_r;

  // stage Q: quotient known, bucket formed, row read issued
  logic             q_valid_r;
  logic             q_cmd_r;
  logic [KEY_W-1:0] q_key_r;
  logic [PAY_W-1:0] q_pay_r;
  logic [KEY_W-1:0] q_quot_r;

  // stage C: row data present, compare and write back
  logic             c_valid_r;
  logic             c_cmd_r;
  logic [KEY_W-1:0] c_key_r;
  logic [PAY_W-1:0] c_pay_r;
  logic [BKT_W-1:0] c_bucket_r;

  logic [WAYS-1:0]            rd_occ_r;
  logic [WAYS-1:0][KEY_W-1:0] rd_key_r;
  logic [WAYS-1:0][PAY_W-1:0] rd_pay_r;
  logic                       fwd_hit_r;
  logic [WAYS-1:0]            fwd_occ_r;
  logic [WAYS-1:0][KEY_W-1:0] fwd_key_r;
  logic [WAYS-1:0][PAY_W-1:0] fwd_pay_r;

  // result register
  logic                       out_valid_r;
  logic                       out_found_r;
  logic [PAY_W-1:0]           out_payload_r;
  pkht_pkg::status_t          out_status_r;

  // handshake chain
  logic out_free, c_free, q_free, p_free;
  logic c_adv, q_adv, p_adv, in_xfer;

  assign out_free = !out_valid_r || out_if.ready;
  assign c_adv    = c_valid_r && out_free;
  assign c_free   = !c_valid_r || out_free;
  assign q_adv    = q_valid_r && c_free;
  assign q_free   = !q_valid_r || c_free;
  assign p_adv    = p_valid_r && q_free;
  assign p_free   = !p_valid_r || q_free;

  assign in_if.ready = !clr_active_r && p_free;
  assign in_xfer     = in_if.valid && in_if.ready;

  // bucket reduction
  logic [2*KEY_W:0]   p_prod;
  logic [2*KEY_W:0]   p_quot_full;
  logic [KEY_W+BKT_W:0] q_mul;
  logic [KEY_W-1:0]   q_rem;
  logic [BKT_W-1:0]   q_bucket;

  assign p_prod      = p_key_r * MUL_M;
  assign p_quot_full = p_prod >> RECIP_S;
  assign q_mul       = q_quot_r * BKT_NUM;
  assign q_rem       = q_key_r - q_mul[KEY_W-1:0];
  assign q_bucket    = q_rem[BKT_W-1:0];

  // compare and update
  logic [WAYS-1:0]            eff_occ;
  logic [WAYS-1:0][KEY_W-1:0] eff_key;
  logic [WAYS-1:0][PAY_W-1:0] eff_pay;
  logic [WAYS-1:0]            new_occ;
  logic [WAYS-1:0][KEY_W-1:0] new_key;
  logic [WAYS-1:0][PAY_W-1:0] new_pay;
  logic                       free_hit, match_hit;
  logic [WAY_W-1:0]           free_idx, match_idx;
  logic                       c_wr_en, c_wr;
  logic                       c_found;
  logic [PAY_W-1:0]           c_pout;
  pkht_pkg::status_t          c_status;

  always_comb begin
    eff_occ   = fwd_hit_r ? fwd_occ_r : rd_occ_r;
    eff_key   = fwd_hit_r ? fwd_key_r : rd_key_r;
    eff_pay   = fwd_hit_r ? fwd_pay_r : rd_pay_r;
    free_hit  = 1'b0;
    free_idx  = '0;
    match_hit = 1'b0;
    match_idx = '0;
    // scan from the top so the lowest way wins
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (!eff_occ[w]) begin
        free_hit = 1'b1;
        free_idx = WAY_W'(w);
      end
      if (eff_occ[w] && (eff_key[w] == c_key_r)) begin
        match_hit = 1'b1;
        match_idx = WAY_W'(w);
      end
    end
    new_occ           = eff_occ;
    new_key           = eff_key;
    new_pay           = eff_pay;
    new_occ[free_idx] = 1'b1;
    new_key[free_idx] = c_key_r;
    new_pay[free_idx] = c_pay_r;

    c_wr_en  = 1'b0;
    c_found  = 1'b0;
    c_pout   = '0;
    c_status = pkht_pkg::STAT_OK;
    if (c_cmd_r == pkht_pkg::CMD_ADD) begin
      if (c_pay_r == '0) begin
        c_status = pkht_pkg::STAT_ZERO;
      end else if (!free_hit) begin
        c_status = pkht_pkg::STAT_FULL;
      end else begin
        c_wr_en = 1'b1;
      end
    end else if (match_hit) begin
      c_found = 1'b1;
      c_pout  = eff_pay[match_idx];
    end
  end

  assign c_wr = c_adv && c_wr_en;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_idx_r    <= '0;
      p_valid_r    <= 1'b0;
      q_valid_r    <= 1'b0;
      c_valid_r    <= 1'b0;
      out_valid_r  <= 1'b0;
      fwd_hit_r    <= 1'b0;
    end else begin
      if (clr_active_r) begin
        clr_idx_r <= clr_idx_r + 1'b1;
        if (clr_idx_r == BKT_W'(BUCKETS - 1)) begin
          clr_active_r <= 1'b0;
        end
      end
      if (p_free) p_valid_r <= in_xfer;
      if (q_free) q_valid_r <= p_adv;
      if (c_free) c_valid_r <= q_adv;
      if (out_free) out_valid_r <= c_adv;
      // forward the row written in the same cycle as this read
      if (q_adv) fwd_hit_r <= c_wr && (c_bucket_r == q_bucket);
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      p_cmd_r <= in_if.command;
      p_key_r <= in_if.pid_key;
      p_pay_r <= in_if.payload_in;
    end
    if (p_adv) begin
      q_cmd_r  <= p_cmd_r;
      q_key_r  <= p_key_r;
      q_pay_r  <= p_pay_r;
      q_quot_r <= p_quot_full[KEY_W-1:0];
    end
    if (q_adv) begin
      c_cmd_r    <= q_cmd_r;
      c_key_r    <= q_key_r;
      c_pay_r    <= q_pay_r;
      c_bucket_r <= q_bucket;
      fwd_occ_r  <= new_occ;
      fwd_key_r  <= new_key;
      fwd_pay_r  <= new_pay;
    end
    if (c_adv) begin
      out_found_r   <= c_found;
      out_payload_r <= c_pout;
      out_status_r  <= c_status;
    end
  end

  // bucket row memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (clr_active_r) begin
      occ_mem[clr_idx_r] <= '0;
    end else if (c_wr) begin
      occ_mem[c_bucket_r] <= new_occ;
      key_mem[c_bucket_r] <= new_key;
      pay_mem[c_bucket_r] <= new_pay;
    end
    if (q_adv) begin
      rd_occ_r <= occ_mem[q_bucket];
      rd_key_r <= key_mem[q_bucket];
      rd_pay_r <= pay_mem[q_bucket];
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.found       = out_found_r;
  assign out_if.payload_out = out_payload_r;
  assign out_if.status      = out_status_r;

endmodule

// ----- design/pkht_checker.sv -----
module pkht_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_found,
  input logic [pkht_pkg::PAY_W-1:0]  out_payload,
  input logic [pkht_pkg::STAT_W-1:0] out_status
);

  // a result that is not taken stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // stored handles are never zero, and a hit is never an add status
  a_hit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_payload != '0 && out_status == pkht_pkg::STAT_OK)
    else $error("hit with zero payload or error status");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_payload == '0)
    else $error("miss with nonzero payload");

  // the clearing pass holds off input right after reset
  a_clear_hold: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input taken before table cleared");

endmodule

bind pid_keyed_hash_table pkht_checker u_pkht_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_if.ready),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .out_found   (out_if.found),
  .out_payload (out_if.payload_out),
  .out_status  (out_if.status)
);

// ----- test/tb.sv -----
module tb;

  localparam int BUCKETS     = pkht_pkg::BUCKETS_DEF;
  localparam int WAYS        = pkht_pkg::WAYS_DEF;
  localparam int SLOTS       = BUCKETS * WAYS;
  localparam int KEY_W       = pkht_pkg::KEY_W;
  localparam int PAY_W       = pkht_pkg::PAY_W;
  localparam int CYCLE_LIMIT = 600000;
  localparam int HOT_BUCKETS = 8;
  localparam int HOT_KEYS    = HOT_BUCKETS * 3;

  typedef struct packed {
    logic               found;
    logic [PAY_W-1:0]   payload;
    pkht_pkg::status_t  status;
  } lookup_result_t;

  logic clk;
  logic rst_n;

  pkht_in_if  in_if();
  pkht_out_if out_if();

  pid_keyed_hash_table dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  // shadow copy of the table
  logic [KEY_W-1:0] shadow_key[SLOTS];
  logic [PAY_W-1:0] shadow_pay[SLOTS];
  bit               shadow_used[SLOTS];

  lookup_result_t pending_results[$];
  int             error_count = 0;
  int             cycle_count = 0;
  int             send_idle_pct;
  int             recv_idle_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic lookup_result_t table_predict(input pkht_pkg::cmd_t cmd,
                                                   input logic [KEY_W-1:0] key,
                                                   input logic [PAY_W-1:0] pay);
    lookup_result_t r;
    int             base;
    bit             done;
    r.found   = 1'b0;
    r.payload = '0;
    r.status  = pkht_pkg::STAT_OK;
    base = int'(key % BUCKETS) * WAYS;
    done = 1'b0;
    if (cmd == pkht_pkg::CMD_ADD) begin
      if (pay == '0) begin
        r.status = pkht_pkg::STAT_ZERO;
      end else begin
        r.status = pkht_pkg::STAT_FULL;
        for (int w = 0; w < WAYS; w++) begin
          if (!done && !shadow_used[base + w]) begin
            shadow_key[base + w]  = key;
            shadow_pay[base + w]  = pay;
            shadow_used[base + w] = 1'b1;
            r.status = pkht_pkg::STAT_OK;
            done = 1'b1;
          end
        end
      end
    end else begin
      for (int w = 0; w < WAYS; w++) begin
        if (!done && shadow_used[base + w] && shadow_key[base + w] == key) begin
          r.found   = 1'b1;
          r.payload = shadow_pay[base + w];
          done = 1'b1;
        end
      end
    end
    return r;
  endfunction

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("ERROR: %s", msg);
  endtask

  task automatic send_cmd(input pkht_pkg::cmd_t cmd, input logic [KEY_W-1:0] key,
                          input logic [PAY_W-1:0] pay);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.command    <= cmd;
    in_if.pid_key    <= key;
    in_if.payload_in <= pay;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    pending_results.push_back(table_predict(cmd, key, pay));
  endtask

  always @(posedge clk) begin
    out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin : check_results
    lookup_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        flag_error($sformatf("result with nothing pending: found=%0b payload=%08h status=%0d",
                             out_if.found, out_if.payload_out, out_if.status));
      end else begin
        want = pending_results.pop_front();
        if (out_if.found !== want.found || out_if.payload_out !== want.payload ||
            out_if.status !== want.status) begin
          flag_error($sformatf({"expected found=%0b payload=%08h status=%0d, ",
                                "got found=%0b payload=%08h status=%0d"},
                               want.found, want.payload, want.status,
                               out_if.found, out_if.payload_out, out_if.status));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("pid_keyed_hash_table: mismatch");
      $finish;
    end
  end

  // extremes, zero payload, full bucket, duplicates and misses
  task automatic test_special_cases;
    send_cmd(pkht_pkg::CMD_GET, 20'h00000, 32'h0000_0000);
    send_cmd(pkht_pkg::CMD_ADD, 20'h00000, 32'h0000_0000);
    send_cmd(pkht_pkg::CMD_ADD, 20'h00000, 32'hFFFF_FFFF);
    send_cmd(pkht_pkg::CMD_GET, 20'h00000, 32'hFFFF_FFFF);
    send_cmd(pkht_pkg::CMD_GET, 20'h00100, 32'h0000_0000);
    send_cmd(pkht_pkg::CMD_ADD, 20'hFFFFF, 32'h0000_0001);
    send_cmd(pkht_pkg::CMD_GET, 20'hFFFFF, 32'h0000_0000);
    send_cmd(pkht_pkg::CMD_ADD, 20'h000FF, 32'h8000_0000);
    send_cmd(pkht_pkg::CMD_ADD, 20'hFFFFF, 32'h1234_5678);
    send_cmd(pkht_pkg::CMD_ADD, 20'h001FF, 32'hA5A5_A5A5);
    send_cmd(pkht_pkg::CMD_ADD, 20'hFFFFF, 32'h0000_0005);
    send_cmd(pkht_pkg::CMD_ADD, 20'hFFFFF, 32'h0000_0000);
    send_cmd(pkht_pkg::CMD_GET, 20'h001FF, 32'h5A5A_5A5A);
    send_cmd(pkht_pkg::CMD_GET, 20'hFFFFF, 32'h0000_0000);
    send_cmd(pkht_pkg::CMD_GET, 20'h000FF, 32'hFFFF_FFFF);
    send_cmd(pkht_pkg::CMD_GET, 20'h002FF, 32'h0000_0000);
    send_cmd(pkht_pkg::CMD_ADD, 20'h7FFFF, 32'h7FFF_FFFF);
    send_cmd(pkht_pkg::CMD_GET, 20'h7FFFF, 32'h0000_0000);
    send_cmd(pkht_pkg::CMD_GET, 20'hFFEFF, 32'h0000_0000);
  endtask

  // traffic centered on a few buckets so they fill, collide and overflow
  task automatic test_random_traffic(input int count);
    logic [KEY_W-1:0] hot_keys[HOT_KEYS];
    int               bucket[HOT_BUCKETS];
    int               r;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] pay;
    for (int b = 0; b < HOT_BUCKETS; b++) bucket[b] = $urandom_range(BUCKETS - 1);
    for (int i = 0; i < HOT_KEYS; i++) begin
      hot_keys[i] = KEY_W'(bucket[i / 3] + BUCKETS * $urandom_range(4095));
    end
    for (int n = 0; n < count; n++) begin
      r   = $urandom_range(99);
      key = hot_keys[$urandom_range(HOT_KEYS - 1)];
      pay = $urandom;
      if (r < 40) begin
        send_cmd(pkht_pkg::CMD_ADD, key, pay);
      end else if (r < 80) begin
        send_cmd(pkht_pkg::CMD_GET, key, pay);
      end else if (r < 90) begin
        key = KEY_W'($urandom);
        send_cmd($urandom_range(1) ? pkht_pkg::CMD_GET : pkht_pkg::CMD_ADD, key, pay);
      end else if (r < 95) begin
        send_cmd(pkht_pkg::CMD_ADD, key, '0);
      end else begin
        // same bucket, most likely a key never added
        key = KEY_W'(bucket[$urandom_range(HOT_BUCKETS - 1)] +
                     BUCKETS * $urandom_range(4095));
        send_cmd(pkht_pkg::CMD_GET, key, pay);
      end
    end
  endtask

  initial begin
    rst_n            = 1'b0;
    in_if.valid      = 1'b0;
    in_if.command    = pkht_pkg::CMD_ADD;
    in_if.pid_key    = '0;
    in_if.payload_in = '0;
    send_idle_pct    = 28;
    recv_idle_pct    = 86;
    for (int i = 0; i < SLOTS; i++) begin
      shadow_key[i]  = '0;
      shadow_pay[i]  = '0;
      shadow_used[i] = 1'b0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_special_cases();
    test_random_traffic(180);
    send_idle_pct = 86;
    recv_idle_pct = 28;
    test_random_traffic(180);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(180);
    in_if.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("pid_keyed_hash_table: match");
    end else begin
      $display("pid_keyed_hash_table: mismatch");
    end
    $finish;
  end
endmodule
